// ===== rtl/core/prq_pkg.sv =====
// prq_pkg: types, codes and constants for the priority retransmit queue
// no dependencies; imported by every module of the block
`default_nettype none
package prq_pkg;

  localparam int unsigned NumCfg = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MaxResults = 32;
  localparam logic [2:0] SendsMax = 3'd7;
  localparam logic [8:0] AgeMax = 9'd511;

  typedef enum logic [2:0] {
    FUNC_ENQ   = 3'd0,
    FUNC_ACK   = 3'd1,
    FUNC_RANGE = 3'd2,
    FUNC_POP   = 3'd3,
    FUNC_AGE   = 3'd4,
    FUNC_SENT  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_CYC_A     = 3'd0,
    CFG_CYC_B     = 3'd1,
    CFG_SER_MAX   = 3'd2,
    CFG_CYC_LIM   = 3'd3,
    CFG_NORM_LIM  = 3'd4,
    CFG_AGE_LIM   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [23:0] source_id;
    logic [23:0] dest_id;
    logic [3:0]  degree;
    logic [15:0] serial;
    logic [15:0] serial_end;
    logic        encrypt;
    logic [15:0] payload_tag;
    logic [9:0]  payload_length;
    logic [5:0]  accept_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] out_source;
    logic [23:0] out_dest;
    logic [15:0] out_serial;
    logic [3:0]  out_degree;
    logic [2:0]  out_send_count;
    logic        out_encrypt;
    logic [15:0] out_tag;
    logic [9:0]  out_length;
    logic [5:0]  removed_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] source;
    logic [23:0] dest;
    logic [3:0]  degree;
    logic [15:0] serial;
    logic        flag;
    logic [15:0] handle;
    logic [9:0]  size;
    logic [2:0]  sends;
    logic [8:0]  age;
  } entry_t;

  typedef struct packed {
    logic [3:0]  cyc_a;
    logic [3:0]  cyc_b;
    logic [15:0] ser_max;
    logic [2:0]  cyc_lim;
    logic [2:0]  norm_lim;
    logic [8:0]  age_lim;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_SENT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item, reset scan
    logic scan_step;  // one scan step over entry at pointer
    logic emit;       // drive a result from current registers
    logic sent_step;  // mark one head entry sent and report it
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic sent_done;
    logic sent_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/prq_ctrl.sv =====
// prq_ctrl: operation sequencer of the priority retransmit queue
// uses prq_pkg; drives the datapath by command structs
`default_nettype none
module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic [2:0] func_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (func_i) inside
            FUNC_ENQ, FUNC_ACK, FUNC_RANGE, FUNC_POP, FUNC_AGE: state_d = S_SCAN;
            FUNC_SENT: state_d = S_SENT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      S_SENT: begin
        if (sts_i.sent_zero) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.sent_step = 1'b1;
          if (sts_i.sent_done) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/prq_dp.sv =====
// prq_dp: entry array, scan pointer and result registers
// uses prq_pkg; commanded by prq_ctrl
`default_nettype none
module prq_dp
  import prq_pkg::*;
#(
  parameter int unsigned QueueDepth = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_sts_t       sts_o,
  output logic          strobe_o,
  output out_item_t     result_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned AccW = ((CntW > 6) ? CntW : 6) + 1;

  // entries live in a shift array: compaction and insertion move whole rows
  entry_t ent_q [QueueDepth];
  entry_t ent_d [QueueDepth];
  logic [CntW-1:0] occ_q, occ_d;
  in_item_t it_q;
  logic [CntW-1:0] ptr_q, ptr_d;      // scan pointer
  logic [CntW-1:0] rem_q, rem_d;      // removed count
  logic found_q, found_d;             // ack/pop/enq hit
  entry_t hit_q, hit_d;               // reported entry
  logic [15:0] done_q [QueueDepth];   // serials removed by range delete
  logic [15:0] done_d [QueueDepth];
  logic strobe_d;
  out_item_t res_q, res_d;

  entry_t cur;
  logic [IdxW-1:0] ptr_idx;
  logic in_rng, seen, del, limit_hit;
  logic [2:0] lim;
  logic [8:0] age_inc;
  logic [5:0] acc_sat;
  logic [CntW-1:0] n_calc;
  logic [AccW-1:0] acc_ext;

  assign ptr_idx = ptr_q[IdxW-1:0];
  assign cur = ent_q[ptr_idx];

  always_comb begin
    in_rng = 1'b0;
    if (it_q.serial <= it_q.serial_end) begin
      in_rng = (cur.serial >= it_q.serial) && (cur.serial <= it_q.serial_end);
    end else begin
      in_rng = (cur.serial <= it_q.serial_end) ||
               ((cur.serial >= it_q.serial) && (cur.serial <= cfg_i.ser_max));
    end
    seen = 1'b0;
    for (int j = 0; j < QueueDepth; j++) begin
      if ((CntW'(j) < rem_q) && (done_q[j] == cur.serial)) seen = 1'b1;
    end
    lim = ((cur.degree == cfg_i.cyc_a) || (cur.degree == cfg_i.cyc_b)) ?
          cfg_i.cyc_lim : cfg_i.norm_lim;
    age_inc = (cur.age < AgeMax) ? cur.age + 9'd1 : cur.age;
    limit_hit = (cur.sends >= lim) || (age_inc > cfg_i.age_lim);
    acc_sat = (it_q.accept_count > 6'(MaxResults)) ? 6'(MaxResults) : it_q.accept_count;
    acc_ext = AccW'(acc_sat);
    n_calc = (acc_ext > AccW'(occ_q)) ? occ_q : CntW'(acc_ext);
  end

  always_comb begin
    ent_d = ent_q;
    occ_d = occ_q;
    ptr_d = ptr_q;
    rem_d = rem_q;
    found_d = found_q;
    hit_d = hit_q;
    done_d = done_q;
    strobe_d = 1'b0;
    res_d = res_q;
    del = 1'b0;
    sts_o = '0;

    if (cmd_i.load) begin
      ptr_d = '0;
      rem_d = '0;
      found_d = 1'b0;
      hit_d = '0;
    end

    if (cmd_i.scan_step) begin
      unique case (func_e'(it_q.func))
        FUNC_ENQ: begin
          // find insert point, then place entry and shift tail by one
          if (occ_q == CntW'(QueueDepth)) begin
            sts_o.scan_done = 1'b1;
          end else if ((ptr_q == occ_q) || (cur.degree > it_q.degree)) begin
            for (int k = QueueDepth - 1; k > 0; k--) begin
              if (CntW'(k) > ptr_q && CntW'(k) <= occ_q) ent_d[k] = ent_q[k-1];
            end
            hit_d.source = it_q.source_id;
            hit_d.dest = it_q.dest_id;
            hit_d.degree = it_q.degree;
            hit_d.serial = it_q.serial;
            hit_d.flag = it_q.encrypt;
            hit_d.handle = it_q.payload_tag;
            hit_d.size = it_q.payload_length;
            hit_d.sends = '0;
            hit_d.age = '0;
            ent_d[ptr_idx] = hit_d;
            occ_d = occ_q + 1'b1;
            found_d = 1'b1;
            sts_o.scan_done = 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        FUNC_ACK: begin
          if (ptr_q >= occ_q) begin
            sts_o.scan_done = 1'b1;
          end else if (cur.source == it_q.source_id && cur.serial == it_q.serial) begin
            hit_d = cur;
            found_d = 1'b1;
            del = 1'b1;
            sts_o.scan_done = 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        FUNC_RANGE: begin
          if (ptr_q >= occ_q) begin
            sts_o.scan_done = 1'b1;
          end else if (cur.source == it_q.source_id && in_rng && !seen) begin
            done_d[rem_q[IdxW-1:0]] = cur.serial;
            rem_d = rem_q + 1'b1;
            del = 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        FUNC_POP: begin
          if (occ_q != '0) begin
            hit_d = cur;
            found_d = 1'b1;
            del = 1'b1;
          end
          sts_o.scan_done = 1'b1;
        end
        FUNC_AGE: begin
          if (ptr_q >= occ_q) begin
            sts_o.scan_done = 1'b1;
          end else if (limit_hit) begin
            rem_d = rem_q + 1'b1;
            del = 1'b1;
          end else begin
            ent_d[ptr_idx].age = age_inc;
            ptr_d = ptr_q + 1'b1;
          end
        end
        default: sts_o.scan_done = 1'b1;
      endcase
      if (del) begin
        for (int k = 0; k < QueueDepth - 1; k++) begin
          if (CntW'(k) >= ptr_q) ent_d[k] = ent_q[k+1];
        end
        occ_d = occ_q - 1'b1;
      end
    end

    if (cmd_i.emit) begin
      strobe_d = 1'b1;
      res_d = '0;
      res_d.last = 1'b1;
      unique case (func_e'(it_q.func))
        FUNC_ENQ: res_d.status = found_q ? ST_DONE : ST_FULL;
        FUNC_ACK: res_d.status = found_q ? ST_DONE : ST_NOTFOUND;
        FUNC_POP: res_d.status = found_q ? ST_DONE : ST_EMPTY;
        FUNC_RANGE: begin
          res_d.status = (rem_q != '0) ? ST_DONE : ST_NOTFOUND;
          res_d.removed_count = 6'(rem_q);
        end
        FUNC_AGE: begin
          res_d.status = ST_DONE;
          res_d.removed_count = 6'(rem_q);
        end
        FUNC_SENT: res_d.status = (occ_q == '0) ? ST_EMPTY : ST_DONE;
        default: res_d.status = ST_DONE;
      endcase
      if (found_q) begin
        res_d.out_source = hit_q.source;
        res_d.out_dest = hit_q.dest;
        res_d.out_serial = hit_q.serial;
        res_d.out_degree = hit_q.degree;
        res_d.out_send_count = hit_q.sends;
        res_d.out_encrypt = hit_q.flag;
        res_d.out_tag = hit_q.handle;
        res_d.out_length = hit_q.size;
        if (func_e'(it_q.func) != FUNC_ENQ) res_d.removed_count = 6'd1;
      end
    end

    sts_o.sent_zero = (n_calc == '0);
    if (cmd_i.sent_step) begin
      hit_d = cur;
      if (cur.sends < SendsMax) hit_d.sends = cur.sends + 3'd1;
      ent_d[ptr_idx] = hit_d;
      strobe_d = 1'b1;
      res_d = '0;
      res_d.status = ST_DONE;
      res_d.out_source = hit_d.source;
      res_d.out_dest = hit_d.dest;
      res_d.out_serial = hit_d.serial;
      res_d.out_degree = hit_d.degree;
      res_d.out_send_count = hit_d.sends;
      res_d.out_encrypt = hit_d.flag;
      res_d.out_tag = hit_d.handle;
      res_d.out_length = hit_d.size;
      res_d.last = (ptr_q + 1'b1 == n_calc);
      sts_o.sent_done = res_d.last;
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      strobe_o <= 1'b0;
    end else begin
      occ_q <= occ_d;
      strobe_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    done_q <= done_d;
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    found_q <= found_d;
    hit_q <= hit_d;
    res_q <= res_d;
    if (cmd_i.load) it_q <= item_i;
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/priority_retransmit_queue.sv =====
// priority retransmit queue: degree-ordered message queue with acks and aging
// enqueue/ack/range/age scan the queue and pop takes the head entry; mark sent
// gives one result per cycle; the scan walks one entry per cycle over the shift
// array, which sets the rate. results are not stallable.
// reset empties the queue and loads the register defaults
`default_nettype none
module priority_retransmit_queue
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire in_item_t        item_i,
  output logic                 result_valid_o,
  output out_item_t            result_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctrl_busy;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cyc_a    <= 4'd0;
      cfg_q.cyc_b    <= 4'd1;
      cfg_q.ser_max  <= 16'd255;
      cfg_q.cyc_lim  <= 3'd6;
      cfg_q.norm_lim <= 3'd3;
      cfg_q.age_lim  <= 9'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CYC_A:    cfg_q.cyc_a    <= cfg_data_i[3:0];
        CFG_CYC_B:    cfg_q.cyc_b    <= cfg_data_i[3:0];
        CFG_SER_MAX:  cfg_q.ser_max  <= cfg_data_i;
        CFG_CYC_LIM:  cfg_q.cyc_lim  <= cfg_data_i[2:0];
        CFG_NORM_LIM: cfg_q.norm_lim <= cfg_data_i[2:0];
        CFG_AGE_LIM:  cfg_q.age_lim  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // sequencer: one transaction at a time
  prq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start & ~ctrl_busy),
    .func_i (item_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy)
  );

  // entry array and result register
  prq_dp #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .strobe_o(result_valid_o),
    .result_o(result_o)
  );

  assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for priority_retransmit_queue, with an in-bench queue predictor
// depends on prq_pkg and the block rtl; directed tests, then random traffic under several settings
module tb;
  import prq_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 40;  // covers a full-depth scan plus margin

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  in_item_t        item_i;
  logic            result_valid_o;
  out_item_t       result_o;
  logic            cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  priority_retransmit_queue #(.QUEUE_DEPTH(Depth)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state: the message queue and the register file
  entry_t    msg_q [Depth];
  int        msg_count;
  cfg_t      cfg;
  out_item_t expected_results[$];
  int        error_count;
  int        cycle_count;

  logic [23:0] source_pool [4] = '{24'h000000, 24'hFFFFFF, 24'h000A01, 24'h5A5A5A};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // generous watchdog, counted in clock cycles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic out_item_t report(entry_t e, status_e st, int removed, bit last);
    out_item_t r;
    r = '0;
    r.status         = st;
    r.out_source     = e.source;
    r.out_dest       = e.dest;
    r.out_serial     = e.serial;
    r.out_degree     = e.degree;
    r.out_send_count = e.sends;
    r.out_encrypt    = e.flag;
    r.out_tag        = e.handle;
    r.out_length     = e.size;
    r.removed_count  = removed[5:0];
    r.last           = last;
    return r;
  endfunction

  // append one expected result at the tail of the scoreboard
  function automatic void queue_result(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic drop_entry(int pos);
    for (int i = pos; i + 1 < msg_count; i++) msg_q[i] = msg_q[i + 1];
    if (msg_count > 0) msg_count--;
  endtask

  function automatic bit serial_in_window(logic [15:0] s, logic [15:0] lo, logic [15:0] hi);
    if (lo <= hi) return s >= lo && s <= hi;
    return s <= hi || (s >= lo && s <= cfg.ser_max);
  endfunction

  // work out the results of one accepted transaction and update the queue
  task automatic predict_queue(in_item_t it);
    entry_t      e;
    int          pos;
    int          n;
    int          removed;
    int          i;
    bit          seen;
    logic [2:0]  lim;
    logic [15:0] gone [Depth];
    e = '0;
    removed = 0;
    case (it.func)
      FUNC_ENQ: begin
        if (msg_count >= Depth) begin
          queue_result(report('0, ST_FULL, 0, 1'b1));
        end else begin
          pos = msg_count;
          for (i = 0; i < msg_count; i++)
            if (msg_q[i].degree > it.degree) begin
              pos = i;
              break;
            end
          for (i = msg_count; i > pos; i--) msg_q[i] = msg_q[i - 1];
          e.source = it.source_id;
          e.dest   = it.dest_id;
          e.degree = it.degree;
          e.serial = it.serial;
          e.flag   = it.encrypt;
          e.handle = it.payload_tag;
          e.size   = it.payload_length;
          msg_q[pos] = e;
          msg_count++;
          queue_result(report(e, ST_DONE, 0, 1'b1));
        end
      end
      FUNC_ACK: begin
        pos = -1;
        for (i = 0; i < msg_count; i++)
          if (msg_q[i].source == it.source_id && msg_q[i].serial == it.serial) begin
            pos = i;
            break;
          end
        if (pos < 0) begin
          queue_result(report('0, ST_NOTFOUND, 0, 1'b1));
        end else begin
          queue_result(report(msg_q[pos], ST_DONE, 1, 1'b1));
          drop_entry(pos);
        end
      end
      FUNC_RANGE: begin
        // one removal per serial value within a single range delete
        i = 0;
        while (i < msg_count) begin
          seen = 1'b0;
          if (msg_q[i].source == it.source_id &&
              serial_in_window(msg_q[i].serial, it.serial, it.serial_end)) begin
            for (int j = 0; j < removed; j++) if (gone[j] == msg_q[i].serial) seen = 1'b1;
            if (!seen) begin
              gone[removed] = msg_q[i].serial;
              removed++;
              drop_entry(i);
              continue;
            end
          end
          i++;
        end
        queue_result(report('0, removed > 0 ? ST_DONE : ST_NOTFOUND, removed, 1'b1));
      end
      FUNC_POP: begin
        if (msg_count == 0) begin
          queue_result(report('0, ST_EMPTY, 0, 1'b1));
        end else begin
          queue_result(report(msg_q[0], ST_DONE, 1, 1'b1));
          drop_entry(0);
        end
      end
      FUNC_AGE: begin
        i = 0;
        while (i < msg_count) begin
          lim = (msg_q[i].degree == cfg.cyc_a || msg_q[i].degree == cfg.cyc_b) ?
                cfg.cyc_lim : cfg.norm_lim;
          if (msg_q[i].age != AgeMax) msg_q[i].age = msg_q[i].age + 9'd1;
          if (msg_q[i].sends >= lim || msg_q[i].age > cfg.age_lim) begin
            drop_entry(i);
            removed++;
          end else begin
            i++;
          end
        end
        queue_result(report('0, ST_DONE, removed, 1'b1));
      end
      FUNC_SENT: begin
        n = (it.accept_count > MaxResults) ? MaxResults : it.accept_count;
        if (n > msg_count) n = msg_count;
        if (n == 0) begin
          queue_result(report('0, msg_count == 0 ? ST_EMPTY : ST_DONE, 0, 1'b1));
        end else begin
          for (i = 0; i < n; i++) begin
            if (msg_q[i].sends != SendsMax) msg_q[i].sends = msg_q[i].sends + 3'd1;
            queue_result(report(msg_q[i], ST_DONE, 0, i + 1 == n));
          end
        end
      end
      default: ;  // unused codes leave the queue alone and answer nothing
    endcase
  endtask

  // result checker: results cannot be held off, so every strobe is checked against the next expected result
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, result_o);
        error_count++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (result_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, result_o.status);
          error_count++;
        end
        if (result_o.out_source !== exp_r.out_source) begin
          $display("%0t: out_source expected %h got %h", $time, exp_r.out_source,
                   result_o.out_source);
          error_count++;
        end
        if (result_o.out_dest !== exp_r.out_dest) begin
          $display("%0t: out_dest expected %h got %h", $time, exp_r.out_dest, result_o.out_dest);
          error_count++;
        end
        if (result_o.out_serial !== exp_r.out_serial) begin
          $display("%0t: out_serial expected %h got %h", $time, exp_r.out_serial,
                   result_o.out_serial);
          error_count++;
        end
        if (result_o.out_degree !== exp_r.out_degree) begin
          $display("%0t: out_degree expected %0d got %0d", $time, exp_r.out_degree,
                   result_o.out_degree);
          error_count++;
        end
        if (result_o.out_send_count !== exp_r.out_send_count) begin
          $display("%0t: out_send_count expected %0d got %0d", $time, exp_r.out_send_count,
                   result_o.out_send_count);
          error_count++;
        end
        if (result_o.out_encrypt !== exp_r.out_encrypt) begin
          $display("%0t: out_encrypt expected %b got %b", $time, exp_r.out_encrypt,
                   result_o.out_encrypt);
          error_count++;
        end
        if (result_o.out_tag !== exp_r.out_tag) begin
          $display("%0t: out_tag expected %h got %h", $time, exp_r.out_tag, result_o.out_tag);
          error_count++;
        end
        if (result_o.out_length !== exp_r.out_length) begin
          $display("%0t: out_length expected %0d got %0d", $time, exp_r.out_length,
                   result_o.out_length);
          error_count++;
        end
        if (result_o.removed_count !== exp_r.removed_count) begin
          $display("%0t: removed_count expected %0d got %0d", $time, exp_r.removed_count,
                   result_o.removed_count);
          error_count++;
        end
        if (result_o.last !== exp_r.last) begin
          $display("%0t: last expected %b got %b", $time, exp_r.last, result_o.last);
          error_count++;
        end
      end
    end
  end

  // one transaction: random gap, then hold start until busy is low at an edge
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;  // back-to-back stretches
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_queue(it);
  endtask

  // sender pause until every expected result has come, then let the block settle
  task automatic drain_queue();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // enable is left high here; the caller drops it after the last write
  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_CYC_A:    cfg.cyc_a    = value[3:0];
      CFG_CYC_B:    cfg.cyc_b    = value[3:0];
      CFG_SER_MAX:  cfg.ser_max  = value;
      CFG_CYC_LIM:  cfg.cyc_lim  = value[2:0];
      CFG_NORM_LIM: cfg.norm_lim = value[2:0];
      CFG_AGE_LIM:  cfg.age_lim  = value[8:0];
      default: ;
    endcase
  endtask

  task automatic set_all_regs(logic [3:0] a, logic [3:0] b, logic [15:0] smax,
                              logic [2:0] clim, logic [2:0] nlim, logic [8:0] alim);
    drain_queue();
    write_reg(CFG_CYC_A, {12'd0, a});
    write_reg(CFG_CYC_B, {12'd0, b});
    write_reg(CFG_SER_MAX, smax);
    write_reg(CFG_CYC_LIM, {13'd0, clim});
    write_reg(CFG_NORM_LIM, {13'd0, nlim});
    write_reg(CFG_AGE_LIM, {7'd0, alim});
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(func_e f, logic [23:0] src, logic [3:0] deg,
                                         logic [15:0] ser, logic [15:0] ser_end,
                                         logic [5:0] accept);
    in_item_t it;
    it.func           = f;
    it.source_id      = src;
    it.dest_id        = 24'($urandom_range(0, 24'hFFFFFF));
    it.degree         = deg;
    it.serial         = ser;
    it.serial_end     = ser_end;
    it.encrypt        = 1'($urandom_range(0, 1));
    it.payload_tag    = 16'($urandom_range(0, 16'hFFFF));
    it.payload_length = 10'($urandom_range(0, 1023));
    it.accept_count   = accept;
    return it;
  endfunction

  // mostly well-formed traffic: acks and range deletes aim at queued messages
  function automatic in_item_t random_item();
    in_item_t    it;
    int          pick;
    int          k;
    logic [15:0] ser;
    logic [23:0] src;
    logic [3:0]  deg;
    logic [5:0]  acc;
    pick = $urandom_range(0, 99);
    src  = source_pool[$urandom_range(0, 3)];
    deg  = 4'($urandom_range(0, 15));
    acc  = 6'($urandom_range(0, 63));
    ser  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF)) :
           16'($urandom_range(0, 12));
    if (msg_count > 0 && $urandom_range(0, 3) != 0) begin
      k   = $urandom_range(0, msg_count - 1);
      src = msg_q[k].source;
      if (pick >= 40 && pick < 62) ser = msg_q[k].serial;
    end
    if (pick < 40)
      it = make_item(FUNC_ENQ, src, deg, ser, 0, acc);
    else if (pick < 52)
      it = make_item(FUNC_ACK, src, deg, ser, 0, acc);
    else if (pick < 62)
      it = make_item(FUNC_RANGE, src, deg,
                     ser - 16'($urandom_range(0, 3)), ser + 16'($urandom_range(0, 6)) - 16'd2,
                     acc);
    else if (pick < 72)
      it = make_item(FUNC_POP, src, deg, ser, 0, acc);
    else if (pick < 83)
      it = make_item(FUNC_AGE, src, deg, ser, 0, acc);
    else if (pick < 97)
      it = make_item(FUNC_SENT, src, deg, ser, 0,
                     ($urandom_range(0, 4) == 0) ? acc : 6'($urandom_range(0, 4)));
    else begin
      it = make_item(FUNC_ENQ, src, 0, ser, 0, 0);
      it.func = 3'($urandom_range(6, 7));  // undefined codes: ignored by the block
    end
    return it;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // empty-queue answers, ordering by degree, field extremes, every operation
  task automatic test_directed();
    send_item(make_item(FUNC_POP, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 6'd63));
    send_item(make_item(FUNC_ACK, 24'hFFFFFF, 0, 16'hFFFF, 0, 0));
    send_item(make_item(FUNC_RANGE, 24'hFFFFFF, 0, 0, 16'hFFFF, 0));
    send_item(make_item(FUNC_AGE, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_ENQ, 24'hFFFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 6'd63));
    send_item(make_item(FUNC_ENQ, 24'h000000, 4'd0, 16'd0, 16'd0, 0));
    send_item(make_item(FUNC_ENQ, 24'h000A01, 4'd7, 16'd5, 0, 0));
    send_item(make_item(FUNC_ENQ, 24'h000A01, 4'd7, 16'd5, 0, 0));  // equal degree, same serial
    send_item(make_item(FUNC_ENQ, 24'h000A01, 4'd7, 16'd250, 0, 0));
    send_item(make_item(FUNC_ENQ, 24'h000A01, 4'd2, 16'd1, 0, 0));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 0));  // zero accept with a non-empty queue
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 6'd2));
    // wrapped range 250..serial_max plus 0..5: duplicate serial 5 goes only once
    send_item(make_item(FUNC_RANGE, 24'h000A01, 0, 16'd250, 16'd5, 0));
    send_item(make_item(FUNC_ACK, 24'h000A01, 0, 16'd5, 0, 0));
    send_item(make_item(FUNC_ACK, 24'h000A01, 0, 16'd5, 0, 0));
    send_item(make_item(FUNC_RANGE, 24'hFFFFFF, 0, 16'd300, 16'd2, 0));  // start past serial_max
    send_item(make_item(FUNC_POP, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 6'd40));
    begin
      in_item_t junk;
      junk = make_item(FUNC_ENQ, 24'h123456, 4'd3, 16'd9, 0, 0);
      junk.func = 3'd7;
      send_item(junk);
    end
    send_item(make_item(FUNC_AGE, 0, 0, 0, 0, 0));
  endtask

  // fill to the brim with at least one overflow, then report all 32 at once and age
  task automatic test_full_queue();
    for (int i = 0; i < Depth + 1; i++)
      send_item(make_item(FUNC_ENQ, source_pool[i % 4], 4'($urandom_range(0, 15)),
                          16'(i), 0, 0));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 6'd32));
    send_item(make_item(FUNC_SENT, 0, 0, 0, 0, 6'd63));
    send_item(make_item(FUNC_AGE, 0, 0, 0, 0, 0));
    run_random(20);
  endtask

  // tight limits: one-tick aging, small serial space, a cyclic limit of zero
  task automatic test_tight_limits();
    set_all_regs(4'd15, 4'd15, 16'd1, 3'd0, 3'd1, 9'd1);
    run_random(70);
    set_all_regs(4'd3, 4'd9, 16'd8, 3'd1, 3'd7, 9'd4);
    run_random(70);
  endtask

  // loose limits: widest serial space, oldest age
  task automatic test_loose_limits();
    set_all_regs(4'd0, 4'd1, 16'hFFFF, 3'd7, 3'd7, 9'd510);
    run_random(60);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    error_count = 0;
    cycle_count = 0;
    msg_count   = 0;
    cfg = '{cyc_a: 4'd0, cyc_b: 4'd1, ser_max: 16'd255, cyc_lim: 3'd6,
            norm_lim: 3'd3, age_lim: 9'd300};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    run_random(60);  // reset register settings
    test_full_queue();
    test_tight_limits();
    test_loose_limits();
    drain_queue();

    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
